// ----- rtl/utsp_pkg.sv -----
// Shared types, character codes and calendar tables for the UTC timestamp parser.
package utsp_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int YEAR_W      = 14;
	localparam int FIELD_W     = 7;
	localparam int EPOCH_W     = 39;
	localparam int POS_W       = 5;

	localparam logic [POS_W-1:0] TEXT_LENGTH  = 5'd20;
	localparam logic [POS_W-1:0] POS_SATURATE = 5'd21;

	localparam logic [7:0] CHAR_DASH  = 8'h2D;
	localparam logic [7:0] CHAR_T     = 8'h54;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_Z     = 8'h5A;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic [FIELD_W-1:0] MAX_HOUR   = 7'd23;
	localparam logic [FIELD_W-1:0] MAX_MINUTE = 7'd59;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_LAYOUT = 2'd1,
		STATUS_DIGIT  = 2'd2,
		STATUS_RANGE  = 2'd3
	} status_t;

	typedef struct packed {
		logic               layout_bad;
		logic               digit_bad;
		logic [YEAR_W-1:0]  year;
		logic [FIELD_W-1:0] month;
		logic [FIELD_W-1:0] day;
		logic [FIELD_W-1:0] hour;
		logic [FIELD_W-1:0] minute;
		logic [FIELD_W-1:0] second;
	} rec_t;

	function automatic logic [8:0] month_offset(input logic [FIELD_W-1:0] month);
		logic [8:0] r;
		case (month)
			7'd3:    r = 9'd0;
			7'd4:    r = 9'd31;
			7'd5:    r = 9'd61;
			7'd6:    r = 9'd92;
			7'd7:    r = 9'd122;
			7'd8:    r = 9'd153;
			7'd9:    r = 9'd184;
			7'd10:   r = 9'd214;
			7'd11:   r = 9'd245;
			7'd12:   r = 9'd275;
			7'd1:    r = 9'd306;
			7'd2:    r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] month_days(input logic [FIELD_W-1:0] month,
	                                          input logic leap);
		logic [4:0] r;
		case (month)
			7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: r = 5'd31;
			7'd4, 7'd6, 7'd9, 7'd11:                    r = 5'd30;
			7'd2:                                       r = leap ? 5'd29 : 5'd28;
			default:                                    r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/utc_timestamp_parser_core.sv -----
// Top level of the UTC timestamp parser: front end, record queue and back end.
// The block takes one byte of a 20-byte timestamp text per cycle whenever full is
// low. When the last byte arrives the front end queues the collected fields (two
// records deep) and is at once ready for the next text. The back end validates
// and converts a record through a sequencer of states (divide, leap, check, days,
// scale, done), and holds the result in an output register until it is popped,
// so a new text can stream in while a result waits.
module utc_timestamp_parser_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [7:0]                          text_byte,
	input  logic                                last_byte,
	output logic                                empty,
	input  logic                                pop,
	output logic [1:0]                          status,
	output logic signed [utsp_pkg::EPOCH_W-1:0] epoch_seconds
);

	logic           accept;
	logic           rec_push;
	utsp_pkg::rec_t rec_in;
	logic           rec_pop;
	logic           rec_valid;
	utsp_pkg::rec_t rec_out;

	assign accept = push && !full;

	utsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.text_byte (text_byte),
		.last_byte (last_byte),
		.rec_push  (rec_push),
		.rec_data  (rec_in)
	);

	utsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rec_push),
		.push_data (rec_in),
		.full      (full),
		.pop       (rec_pop),
		.valid     (rec_valid),
		.pop_data  (rec_out)
	);

	utsp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.rec_valid     (rec_valid),
		.rec_in        (rec_out),
		.rec_pop       (rec_pop),
		.empty         (empty),
		.pop           (pop),
		.status        (status),
		.epoch_seconds (epoch_seconds)
	);

endmodule

// ----- rtl/utsp_front.sv -----
// Front end: checks layout and digits byte by byte and collects the decimal fields.
module utsp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          text_byte,
	input  logic                last_byte,
	output logic                rec_push,
	output utsp_pkg::rec_t      rec_data
);

	logic [utsp_pkg::POS_W-1:0]   pos_q, pos_n;
	logic                         layout_q, layout_n;
	logic                         digit_q, digit_n;
	logic [utsp_pkg::YEAR_W-1:0]  year_q, year_n;
	logic [utsp_pkg::FIELD_W-1:0] month_q, month_n, day_q, day_n;
	logic [utsp_pkg::FIELD_W-1:0] hour_q, hour_n, minute_q, minute_n, second_q, second_n;
	logic                         is_digit;
	logic [3:0]                   dig;

	function automatic logic [utsp_pkg::FIELD_W-1:0] add7(
		input logic [utsp_pkg::FIELD_W-1:0] acc, input logic [3:0] d);
		return {acc[utsp_pkg::FIELD_W-4:0], 3'b000} + {acc[utsp_pkg::FIELD_W-2:0], 1'b0}
		     + {{(utsp_pkg::FIELD_W-4){1'b0}}, d};
	endfunction

	function automatic logic [utsp_pkg::YEAR_W-1:0] add14(
		input logic [utsp_pkg::YEAR_W-1:0] acc, input logic [3:0] d);
		return {acc[utsp_pkg::YEAR_W-4:0], 3'b000} + {acc[utsp_pkg::YEAR_W-2:0], 1'b0}
		     + {{(utsp_pkg::YEAR_W-4){1'b0}}, d};
	endfunction

	assign is_digit = (text_byte >= utsp_pkg::CHAR_ZERO) && (text_byte <= utsp_pkg::CHAR_NINE);
	assign dig      = is_digit ? 4'(text_byte - utsp_pkg::CHAR_ZERO) : 4'd0;

	always_comb begin
		layout_n = layout_q;
		digit_n  = digit_q;
		year_n   = year_q;
		month_n  = month_q;
		day_n    = day_q;
		hour_n   = hour_q;
		minute_n = minute_q;
		second_n = second_q;
		case (pos_q)
			5'd4, 5'd7: begin
				if (text_byte != utsp_pkg::CHAR_DASH) layout_n = 1'b1;
			end
			5'd10: begin
				if (text_byte != utsp_pkg::CHAR_T) layout_n = 1'b1;
			end
			5'd13, 5'd16: begin
				if (text_byte != utsp_pkg::CHAR_COLON) layout_n = 1'b1;
			end
			5'd19: begin
				if (text_byte != utsp_pkg::CHAR_Z) layout_n = 1'b1;
			end
			default: begin
				if (pos_q < utsp_pkg::TEXT_LENGTH) begin
					if (!is_digit) begin
						digit_n = 1'b1;
					end else if (pos_q < 5'd4) begin
						year_n = add14(year_q, dig);
					end else if (pos_q < 5'd7) begin
						month_n = add7(month_q, dig);
					end else if (pos_q < 5'd10) begin
						day_n = add7(day_q, dig);
					end else if (pos_q < 5'd13) begin
						hour_n = add7(hour_q, dig);
					end else if (pos_q < 5'd16) begin
						minute_n = add7(minute_q, dig);
					end else begin
						second_n = add7(second_q, dig);
					end
				end
			end
		endcase
		pos_n = (pos_q < utsp_pkg::POS_SATURATE) ? pos_q + 5'd1 : pos_q;
	end

	assign rec_push            = accept && last_byte;
	assign rec_data.layout_bad = layout_n || (pos_n != utsp_pkg::TEXT_LENGTH);
	assign rec_data.digit_bad  = digit_n;
	assign rec_data.year       = year_n;
	assign rec_data.month      = month_n;
	assign rec_data.day        = day_n;
	assign rec_data.hour       = hour_n;
	assign rec_data.minute     = minute_n;
	assign rec_data.second     = second_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			layout_q <= 1'b0;
			digit_q  <= 1'b0;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
		end else if (accept) begin
			if (last_byte) begin
				pos_q    <= '0;
				layout_q <= 1'b0;
				digit_q  <= 1'b0;
				year_q   <= '0;
				month_q  <= '0;
				day_q    <= '0;
				hour_q   <= '0;
				minute_q <= '0;
				second_q <= '0;
			end else begin
				pos_q    <= pos_n;
				layout_q <= layout_n;
				digit_q  <= digit_n;
				year_q   <= year_n;
				month_q  <= month_n;
				day_q    <= day_n;
				hour_q   <= hour_n;
				minute_q <= minute_n;
				second_q <= second_n;
			end
		end
	end

endmodule

// ----- rtl/utsp_queue.sv -----
// Short queue of collected timestamp records between the front and back ends.
module utsp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  utsp_pkg::rec_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output utsp_pkg::rec_t pop_data
);

	localparam int PTR_W = (utsp_pkg::QUEUE_DEPTH > 1) ? $clog2(utsp_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(utsp_pkg::QUEUE_DEPTH + 1);

	utsp_pkg::rec_t   mem_q [utsp_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full     = (cnt_q == CNT_W'(utsp_pkg::QUEUE_DEPTH));
	assign valid    = (cnt_q != '0);
	assign pop_data = mem_q[rd_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(utsp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(utsp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/utsp_back.sv -----
// Back end: validates the calendar fields and converts them to epoch seconds.
module utsp_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                rec_valid,
	input  utsp_pkg::rec_t                      rec_in,
	output logic                                rec_pop,
	output logic                                empty,
	input  logic                                pop,
	output logic [1:0]                          status,
	output logic signed [utsp_pkg::EPOCH_W-1:0] epoch_seconds
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_DIV   = 7'b0000010,
		ST_LEAP  = 7'b0000100,
		ST_CHECK = 7'b0001000,
		ST_DAYS  = 7'b0010000,
		ST_SCALE = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t                              state_q;
	utsp_pkg::rec_t                      rec_q;
	logic [13:0]                         yy_q;
	logic [6:0]                          qy_q, qyy_q;
	logic                                leap_q;
	utsp_pkg::status_t                   st_q;
	logic [21:0]                         days_a_q;
	logic [9:0]                          doy_q;
	logic [18:0]                         tod_q;
	logic signed [24:0]                  days_q;
	logic signed [utsp_pkg::EPOCH_W-1:0] secs_q;
	logic                                out_valid_q;
	logic [1:0]                          out_status_q;
	logic signed [utsp_pkg::EPOCH_W-1:0] out_epoch_q;

	logic [26:0]                         prod_y, prod_yy;
	logic [13:0]                         qy_x100;
	logic                                div100;
	logic                                range_bad;
	logic signed [24:0]                  days_sum;
	logic signed [42:0]                  secs_full;
	logic                                load_out;

	assign prod_y   = 27'(rec_q.year) * 27'd5243;
	assign prod_yy  = 27'(yy_q) * 27'd5243;
	assign qy_x100  = 14'(qy_q) * 14'd100;
	assign div100   = (rec_q.year == qy_x100);

	assign range_bad = (rec_q.day == '0)
		|| (rec_q.day > {2'b00, utsp_pkg::month_days(rec_q.month, leap_q)})
		|| (rec_q.hour > utsp_pkg::MAX_HOUR)
		|| (rec_q.minute > utsp_pkg::MAX_MINUTE)
		|| (rec_q.second > utsp_pkg::MAX_MINUTE);

	assign days_sum = $signed({3'b000, days_a_q})
		+ $signed(25'({yy_q[13:2]}))
		- $signed(25'(qyy_q))
		+ $signed(25'(qyy_q[6:2]))
		+ $signed(25'(doy_q))
		- $signed(25'd865566);

	assign secs_full = 43'(days_q) * 43'sd86400;
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || pop);
	assign rec_pop   = (state_q == ST_IDLE) && rec_valid;

	assign empty         = !out_valid_q;
	assign status        = out_status_q;
	assign epoch_seconds = out_epoch_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (rec_valid) rec_q <= rec_in;
			end
			ST_DIV: begin
				yy_q <= rec_q.year + 14'd400 - ((rec_q.month <= 7'd2) ? 14'd1 : 14'd0);
				qy_q <= prod_y[25:19];
			end
			ST_LEAP: begin
				qyy_q  <= prod_yy[25:19];
				leap_q <= ((rec_q.year[1:0] == 2'b00) && !div100)
				       || (div100 && (qy_q[1:0] == 2'b00));
			end
			ST_CHECK: begin
				if (rec_q.layout_bad) begin
					st_q <= utsp_pkg::STATUS_LAYOUT;
				end else if (rec_q.digit_bad) begin
					st_q <= utsp_pkg::STATUS_DIGIT;
				end else if (range_bad) begin
					st_q <= utsp_pkg::STATUS_RANGE;
				end else begin
					st_q <= utsp_pkg::STATUS_OK;
				end
				days_a_q <= 22'(yy_q) * 22'd365;
				doy_q    <= 10'(utsp_pkg::month_offset(rec_q.month)) + 10'(rec_q.day);
				tod_q    <= 19'(rec_q.hour) * 19'd3600 + 19'(rec_q.minute) * 19'd60
				          + 19'(rec_q.second);
			end
			ST_DAYS: begin
				days_q <= days_sum;
			end
			ST_SCALE: begin
				secs_q <= secs_full[utsp_pkg::EPOCH_W-1:0];
			end
			default: begin
			end
		endcase
		if (load_out) begin
			out_status_q <= st_q;
			out_epoch_q  <= (st_q == utsp_pkg::STATUS_OK)
				? secs_q + $signed({20'd0, tod_q}) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE:  if (rec_valid) state_q <= ST_DIV;
				ST_DIV:   state_q <= ST_LEAP;
				ST_LEAP:  state_q <= ST_CHECK;
				ST_CHECK: state_q <= ST_DAYS;
				ST_DAYS:  state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_DONE;
				ST_DONE:  if (load_out) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
